@@ hdl/mtr_pkg.sv @@
package mtr_pkg;

  localparam int unsigned STATE_WORDS = 624;
  localparam int unsigned SHIFT_WORDS = 397;
  localparam int unsigned AddrW       = 10;

  localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
  localparam logic [31:0] INIT_MULT    = 32'd1812433253;
  localparam logic [31:0] SEED_RESET   = 32'd5489;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc60000;
  localparam logic [31:0] UPPER_MASK   = 32'h80000000;
  localparam logic [31:0] LOWER_MASK   = 32'h7fffffff;

  localparam logic [AddrW-1:0] LAST_ADDR  = AddrW'(STATE_WORDS - 1);
  localparam logic [AddrW-1:0] USED_UP    = AddrW'(STATE_WORDS);
  localparam logic [AddrW-1:0] SHIFT_ADDR = AddrW'(SHIFT_WORDS);
  localparam logic [AddrW-1:0] WRAP_ADDR  = AddrW'(STATE_WORDS);

  typedef enum logic [3:0] {
    ST_FILL_WR,
    ST_FILL_MUL,
    ST_IDLE,
    ST_TW_PRIME,
    ST_TW_CACHE,
    ST_TW_LOAD,
    ST_TW_CALC,
    ST_RD,
    ST_TEMPER,
    ST_DIV,
    ST_DONE
  } mtr_state_e;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] rem;
  } mod_rsp_t;

  function automatic logic [31:0] temper(input logic [31:0] raw);
    logic [31:0] t;
    t = raw;
    t = t ^ (t >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    t = t ^ (t >> 18);
    return t;
  endfunction

endpackage

@@ hdl/mtr_state_ram.sv @@
module mtr_state_ram (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [mtr_pkg::AddrW-1:0]  waddr_i,
  input  logic [31:0]                wdata_i,
  input  logic [mtr_pkg::AddrW-1:0]  raddr_a_i,
  input  logic [mtr_pkg::AddrW-1:0]  raddr_b_i,
  output logic [31:0]                rdata_a_o,
  output logic [31:0]                rdata_b_o
);

  logic [31:0] mem_q [mtr_pkg::STATE_WORDS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

@@ hdl/mtr_mod_unit.sv @@
module mtr_mod_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mtr_pkg::mod_req_t req_i,
  output mtr_pkg::mod_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] dvd_q, dvd_d;
  logic [31:0] dvs_q, dvs_d;
  logic [31:0] rem_q, rem_d;
  logic [32:0] trial;

  always_comb begin
    trial  = {rem_q, dvd_q[31]};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 5'd31;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = 32'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[31:0];
      end
      dvd_d = {dvd_q[30:0], 1'b0};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

@@ hdl/mersenne_twister_ranged_rng_unit.sv @@
// Channel   | Direction | tdata (low bit up)          | tuser
// s_axis    | in        | low_bound[31:0], span[63:32] | allow_negative
// m_axis    | out       | value[31:0]                  | none
// cfg       | in        | seed[31:0] with cfg_we_i     | none
// After reset and after every seed write the state memory is filled, each word
// written and then multiplied into the next, during which no word is accepted.
// The length of a draw is set by the 32-step serial remainder unit.
// The first draw after a fill, and every 624th draw after it, first regenerates the memory.
// A new word is accepted while the previous result waits in the output register.
module mersenne_twister_ranged_rng_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // low_bound, span
  input  logic [0:0]  s_axis_tuser,  // allow_negative
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // value
);

  localparam int unsigned AW = mtr_pkg::AddrW;

  mtr_pkg::mtr_state_e state_q, state_d;

  logic [AW-1:0] fidx_q, fidx_d;
  logic [31:0]   fword_q, fword_d;
  logic [AW-1:0] tidx_q, tidx_d;
  logic [AW-1:0] didx_q, didx_d;
  logic [31:0]   cur_q, cur_d;
  logic [31:0]   low_q, low_d;
  logic [31:0]   mag_q, mag_d;
  logic          neg_q, neg_d;
  logic          zero_rem_q, zero_rem_d;
  logic          ovalid_q, ovalid_d;
  logic [31:0]   odata_q, odata_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [31:0]   ram_wdata, ram_rdata_a, ram_rdata_b;

  logic [AW-1:0] nxt_addr, far_addr;
  logic [AW-1:0] far_sum;
  logic [31:0]   y_word, tw_word;
  logic [31:0]   span_in, in_mag, r_val, p_mix;
  logic          in_accept, out_free;

  mtr_pkg::mod_req_t mod_req;
  mtr_pkg::mod_rsp_t mod_rsp;

  mtr_state_ram u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  mtr_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  assign out_free  = !ovalid_q || m_axis_tready;
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign span_in   = s_axis_tdata[63:32];
  assign in_mag    = span_in[31] ? (32'd0 - span_in) : span_in;

  assign nxt_addr = (tidx_q == mtr_pkg::LAST_ADDR) ? '0 : tidx_q + AW'(1);
  assign far_sum  = tidx_q + mtr_pkg::SHIFT_ADDR;
  assign far_addr = (far_sum >= mtr_pkg::WRAP_ADDR) ? far_sum - mtr_pkg::WRAP_ADDR : far_sum;

  assign y_word  = (cur_q & mtr_pkg::UPPER_MASK) | (ram_rdata_a & mtr_pkg::LOWER_MASK);
  assign tw_word = ram_rdata_b ^ (y_word >> 1) ^ (y_word[0] ? mtr_pkg::TWIST_MATRIX : '0);
  assign p_mix   = fword_q ^ (fword_q >> 30);
  assign r_val   = zero_rem_q ? '0 : mod_rsp.rem;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mtr_pkg::ST_FILL_WR: begin
        state_d = (fidx_q == mtr_pkg::LAST_ADDR) ? mtr_pkg::ST_IDLE : mtr_pkg::ST_FILL_MUL;
      end
      mtr_pkg::ST_FILL_MUL: state_d = mtr_pkg::ST_FILL_WR;
      mtr_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = (didx_q == mtr_pkg::USED_UP) ? mtr_pkg::ST_TW_PRIME : mtr_pkg::ST_RD;
        end
      end
      mtr_pkg::ST_TW_PRIME: state_d = mtr_pkg::ST_TW_CACHE;
      mtr_pkg::ST_TW_CACHE: state_d = mtr_pkg::ST_TW_LOAD;
      mtr_pkg::ST_TW_LOAD:  state_d = mtr_pkg::ST_TW_CALC;
      mtr_pkg::ST_TW_CALC: begin
        state_d = (tidx_q == mtr_pkg::LAST_ADDR) ? mtr_pkg::ST_RD : mtr_pkg::ST_TW_LOAD;
      end
      mtr_pkg::ST_RD: state_d = mtr_pkg::ST_TEMPER;
      mtr_pkg::ST_TEMPER: begin
        state_d = (mag_q == '0) ? mtr_pkg::ST_DONE : mtr_pkg::ST_DIV;
      end
      mtr_pkg::ST_DIV: begin
        if (mod_rsp.done) begin
          state_d = mtr_pkg::ST_DONE;
        end
      end
      mtr_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = mtr_pkg::ST_IDLE;
        end
      end
      default: state_d = mtr_pkg::ST_IDLE;
    endcase
    if (cfg_we_i) begin
      state_d = mtr_pkg::ST_FILL_WR;
    end
  end

  always_comb begin
    fidx_d       = fidx_q;
    fword_d      = fword_q;
    tidx_d       = tidx_q;
    didx_d       = didx_q;
    cur_d        = cur_q;
    low_d        = low_q;
    mag_d        = mag_q;
    neg_d        = neg_q;
    zero_rem_d   = zero_rem_q;
    ovalid_d     = ovalid_q && !m_axis_tready;
    odata_d      = odata_q;
    ram_we       = 1'b0;
    ram_waddr    = fidx_q;
    ram_wdata    = fword_q;
    ram_raddr_a  = didx_q;
    ram_raddr_b  = far_addr;
    mod_req      = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      mtr_pkg::ST_FILL_WR: begin
        ram_we = 1'b1;
        if (fidx_q == mtr_pkg::LAST_ADDR) begin
          didx_d = mtr_pkg::USED_UP;
        end
      end
      mtr_pkg::ST_FILL_MUL: begin
        fidx_d  = fidx_q + AW'(1);
        fword_d = 32'(p_mix * mtr_pkg::INIT_MULT) + 32'(fidx_d);
      end
      mtr_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_accept) begin
          low_d  = s_axis_tdata[31:0];
          mag_d  = in_mag;
          neg_d  = s_axis_tuser[0] || span_in[31];
          tidx_d = '0;
        end
      end
      mtr_pkg::ST_TW_PRIME: ram_raddr_a = '0;
      mtr_pkg::ST_TW_CACHE: cur_d = ram_rdata_a;
      mtr_pkg::ST_TW_LOAD:  ram_raddr_a = nxt_addr;
      mtr_pkg::ST_TW_CALC: begin
        ram_we    = 1'b1;
        ram_waddr = tidx_q;
        ram_wdata = tw_word;
        cur_d     = ram_rdata_a;
        tidx_d    = tidx_q + AW'(1);
        if (tidx_q == mtr_pkg::LAST_ADDR) begin
          didx_d = '0;
        end
      end
      mtr_pkg::ST_RD: ram_raddr_a = didx_q;
      mtr_pkg::ST_TEMPER: begin
        didx_d           = didx_q + AW'(1);
        neg_d            = neg_q && !ram_rdata_a[3];
        zero_rem_d       = (mag_q == '0);
        mod_req.start    = (mag_q != '0);
        mod_req.dividend = mtr_pkg::temper(ram_rdata_a);
        mod_req.divisor  = mag_q;
      end
      mtr_pkg::ST_DIV: begin
      end
      mtr_pkg::ST_DONE: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          odata_d  = low_q + (neg_q ? (32'd0 - r_val) : r_val);
        end
      end
      default: begin
      end
    endcase
    if (cfg_we_i) begin
      fidx_d  = '0;
      fword_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mtr_pkg::ST_FILL_WR;
      fidx_q   <= '0;
      fword_q  <= mtr_pkg::SEED_RESET;
      tidx_q   <= '0;
      didx_q   <= mtr_pkg::USED_UP;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fidx_q   <= fidx_d;
      fword_q  <= fword_d;
      tidx_q   <= tidx_d;
      didx_q   <= didx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    low_q      <= low_d;
    mag_q      <= mag_d;
    neg_q      <= neg_d;
    zero_rem_q <= zero_rem_d;
    odata_q    <= odata_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

endmodule
